// File: rtl/asf_pkg.sv
package asf_pkg;

  // Defaults for the top-level parameters.
  localparam int CHANNELS_DEFAULT    = 6;
  localparam int WINDOW_MAX_DEFAULT  = 16;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  // Fixed field widths.
  localparam int CHANNEL_W   = 3;
  localparam int MODE_W      = 2;
  localparam int WINDOW_W    = 5;
  localparam int WEIGHT_W    = 16;
  localparam int WEIGHT_FRAC = 15;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(32768);
  localparam int ROUND_HALF = 16384;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = CFG_INDEX_W'(2);

  // Filter modes; the unused code behaves as pass through.
  localparam logic [MODE_W-1:0] MODE_PASS       = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_MOVING_AVG = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LOWPASS    = MODE_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_DELIVER
  } asf_state_t;

endpackage

// File: rtl/asf_div.sv
module asf_div
  import asf_pkg::*;
#(
  parameter int NUM_W = SAMPLE_BITS_DEFAULT + 5,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] quo_next;

  // One restoring step per cycle: the dividend shifts out of quo at the top
  // while quotient bits shift in at the bottom.
  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    diff     = shifted - {1'b0, den};
    fits     = (shifted >= {1'b0, den});
    rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_next = {quo[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= CNT_W'(NUM_W);
      rem   <= '0;
      den   <= divisor;
      quo   <= dividend;
    end else if (busy) begin
      count <= count - CNT_W'(1);
      rem   <= rem_next;
      quo   <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

// File: rtl/asf_mul.sv
module asf_mul
  import asf_pkg::*;
#(
  parameter int MCAND_W = SAMPLE_BITS_DEFAULT + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [MCAND_W-1:0]         mcand,
  input  logic        [WEIGHT_W-1:0]        mplier,
  output logic signed [MCAND_W+WEIGHT_W-1:0] product,
  output logic                              done
);

  localparam int CNT_W = $clog2(WEIGHT_W + 1);

  logic                      busy;
  logic [CNT_W-1:0]          count;
  logic signed [MCAND_W:0]   hi;
  logic [WEIGHT_W-1:0]       lo;
  logic signed [MCAND_W-1:0] m;

  logic signed [MCAND_W:0]   addend;
  logic signed [MCAND_W:0]   sum;

  // Shift-add over the multiplier bits, least significant bit first.
  always_comb begin
    addend = lo[0] ? (MCAND_W+1)'(m) : '0;
    sum    = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      count <= CNT_W'(WEIGHT_W);
      hi    <= '0;
      lo    <= mplier;
      m     <= mcand;
    end else if (busy) begin
      count <= count - CNT_W'(1);
      hi    <= {sum[MCAND_W], sum[MCAND_W:1]};
      lo    <= {sum[0], lo[WEIGHT_W-1:1]};
    end
  end

  assign product = {hi[MCAND_W-1:0], lo};

endmodule

// File: rtl/action_smoothing_filter_core.sv
// Per-channel smoothing of action samples.
// Input items (channel, action_in, restart) are taken on sample_valid while
// sample_stall is low; one result item (channel_out, action_out, bad_channel)
// leaves per input item on result_valid, and is held while result_stall is
// high. The block works on one item at a time; sample_stall is low only while
// it is idle and out of reset. A finished result sits in the output register,
// so the next item is accepted while that result still waits.
// From the accepting edge an item passes through the read and update states;
// moving average then waits in the divide state on the bit-serial divider,
// which yields one quotient bit per cycle, and lowpass waits in the multiply
// state on the 16-step serial multiplier, while pass through and bad channels
// go from update straight to delivery. The block is idle again once the
// result is loaded into the output register.
// Registers are to be written on the cfg port only while the block is idle;
// the block itself does not enforce this. Any write to a defined register,
// and an item with restart set, clears all channel history. Reset restores
// the register defaults, clears the history and empties the output register.
// A long stall on the result side holds the finished item in the delivery
// state until the output register frees up.
module action_smoothing_filter_core
  import asf_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEFAULT,
  parameter int WINDOW_MAX  = WINDOW_MAX_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic        [CHANNEL_W-1:0]   channel,
  input  logic signed [SAMPLE_BITS-1:0] action_in,
  input  logic                          restart,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic        [CHANNEL_W-1:0]   channel_out,
  output logic signed [SAMPLE_BITS-1:0] action_out,
  output logic                          bad_channel,
  input  logic                          cfg_write,
  input  logic        [CFG_INDEX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH    = CHANNELS * WINDOW_MAX;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIFF_W   = SAMPLE_BITS + 1;
  localparam int PROD_W   = DIFF_W + WEIGHT_W;
  localparam int LP_W     = SAMPLE_BITS + 2;

  asf_state_t state, state_next;

  // Configuration registers.
  logic [MODE_W-1:0]   filter_mode;
  logic [WINDOW_W-1:0] window_length;
  logic [WEIGHT_W-1:0] smoothing_weight;

  // Item being worked on.
  logic [CHANNEL_W-1:0]          ch_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          bad_q;
  logic                          neg_q;
  logic [SAMPLE_BITS-1:0]        res_q;

  // Per-channel state.
  logic signed [SUM_W-1:0]       run_sum [CHANNELS];
  logic [CNT_W-1:0]              fill    [CHANNELS];
  logic [SLOT_W-1:0]             oldest  [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] lp_prev [CHANNELS];

  // Sample history, one row of WINDOW_MAX slots per channel.
  logic signed [SAMPLE_BITS-1:0] hist [DEPTH];
  logic signed [SAMPLE_BITS-1:0] hist_rd;

  logic accept;
  logic cfg_clear;
  logic hist_clear;
  logic ma_go;
  logic lp_go;
  logic load_out;
  logic div_start, div_done;
  logic mul_start, mul_done;

  logic [CH_IDX_W-1:0]           ch_idx;
  logic [CNT_W-1:0]              win_act;
  logic signed [SUM_W-1:0]       cur_sum;
  logic [CNT_W-1:0]              cur_fill;
  logic [SLOT_W-1:0]             cur_oldest;
  logic signed [SAMPLE_BITS-1:0] cur_prev;
  logic                          is_full;
  logic [CNT_W:0]                slot_raw;
  logic [CNT_W:0]                slot_wrap;
  logic [SLOT_W-1:0]             wr_slot;
  logic [CNT_W-1:0]              oldest_inc;
  logic [SLOT_W-1:0]             oldest_next;
  logic signed [SUM_W-1:0]       hist_term;
  logic signed [SUM_W-1:0]       sum_next;
  logic [CNT_W-1:0]              fill_next;
  logic [SUM_W-1:0]              sum_mag;
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             wr_addr;
  logic [SUM_W-1:0]              div_quotient;
  logic [SUM_W-1:0]              avg_full;

  logic [WEIGHT_W-1:0]           weight_sat;
  logic signed [DIFF_W-1:0]      lp_diff;
  logic signed [PROD_W-1:0]      mul_product;
  logic signed [PROD_W-1:0]      lp_rnd;
  logic signed [LP_W-1:0]        lp_full;
  logic signed [SAMPLE_BITS-1:0] lp_q;

  assign accept     = sample_valid && !sample_stall;
  assign cfg_clear  = cfg_write && ((cfg_index == REG_FILTER_MODE) ||
                                    (cfg_index == REG_WINDOW_LENGTH) ||
                                    (cfg_index == REG_SMOOTHING_WEIGHT));
  assign hist_clear = cfg_clear || (accept && restart);

  // Window in use: zero acts as one, and anything past the storage saturates.
  always_comb begin
    if (window_length == '0) begin
      win_act = CNT_W'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      win_act = CNT_W'(WINDOW_MAX);
    end else begin
      win_act = CNT_W'(window_length);
    end
  end

  // Moving-average bookkeeping for the current channel. While the window
  // fills, the new sample lands behind the oldest one; once full, the oldest
  // sample is read back, dropped from the sum and overwritten.
  always_comb begin
    ch_idx      = CH_IDX_W'(ch_q);
    cur_sum     = run_sum[ch_idx];
    cur_fill    = fill[ch_idx];
    cur_oldest  = oldest[ch_idx];
    cur_prev    = lp_prev[ch_idx];
    is_full     = (cur_fill >= win_act);
    slot_raw    = (CNT_W+1)'(cur_oldest) + (CNT_W+1)'(cur_fill);
    slot_wrap   = (slot_raw >= (CNT_W+1)'(win_act)) ?
                  slot_raw - (CNT_W+1)'(win_act) : slot_raw;
    wr_slot     = is_full ? cur_oldest : SLOT_W'(slot_wrap);
    oldest_inc  = CNT_W'(cur_oldest) + CNT_W'(1);
    oldest_next = (oldest_inc == win_act) ? '0 : SLOT_W'(oldest_inc);
    hist_term   = is_full ? SUM_W'(hist_rd) : '0;
    sum_next    = cur_sum + SUM_W'(x_q) - hist_term;
    fill_next   = is_full ? cur_fill : cur_fill + CNT_W'(1);
    sum_mag     = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
    rd_addr     = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_MAX) + ADDR_W'(cur_oldest);
    wr_addr     = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_MAX) + ADDR_W'(wr_slot);
    avg_full    = neg_q ? -div_quotient : div_quotient;
  end

  // Lowpass: w*x + (1-w)*prev = prev + w*(x - prev); rounding half up is a
  // bias of one half before the floor shift.
  always_comb begin
    weight_sat = (smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE : smoothing_weight;
    lp_diff    = DIFF_W'(x_q) - DIFF_W'(cur_prev);
    lp_rnd     = mul_product + PROD_W'(ROUND_HALF);
    lp_full    = $signed(lp_rnd[PROD_W-1:WEIGHT_FRAC]) + LP_W'(cur_prev);
    if (lp_full[LP_W-1:SAMPLE_BITS-1] == '0 ||
        lp_full[LP_W-1:SAMPLE_BITS-1] == '1) begin
      lp_q = lp_full[SAMPLE_BITS-1:0];
    end else begin
      lp_q = lp_full[LP_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                               {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  asf_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (fill_next),
    .quotient (div_quotient),
    .done     (div_done)
  );

  asf_mul #(
    .MCAND_W (DIFF_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (lp_diff),
    .mplier  (weight_sat),
    .product (mul_product),
    .done    (mul_done)
  );

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (bad_q) state_next = ST_DELIVER;
        else if (filter_mode == MODE_MOVING_AVG) state_next = ST_DIVIDE;
        else if (filter_mode == MODE_LOWPASS) state_next = ST_MULTIPLY;
        else state_next = ST_DELIVER;
      end
      ST_DIVIDE: begin
        if (div_done) state_next = ST_DELIVER;
      end
      ST_MULTIPLY: begin
        if (mul_done) state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!result_valid || !result_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs. No item is taken while reset is held.
  always_comb begin
    sample_stall = 1'b1;
    ma_go        = 1'b0;
    lp_go        = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_stall = rst;
      end
      ST_UPDATE: begin
        ma_go = !bad_q && (filter_mode == MODE_MOVING_AVG);
        lp_go = !bad_q && (filter_mode == MODE_LOWPASS);
      end
      ST_DELIVER: begin
        load_out = !result_valid || !result_stall;
      end
      default: begin
      end
    endcase
  end

  assign div_start = ma_go;
  assign mul_start = lp_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode      <= MODE_PASS;
      window_length    <= WINDOW_W'(1);
      smoothing_weight <= WEIGHT_ONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FILTER_MODE:      filter_mode      <= cfg_data[MODE_W-1:0];
        REG_WINDOW_LENGTH:    window_length    <= cfg_data[WINDOW_W-1:0];
        REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Per-channel history state. A restart clears it on the accepting edge,
  // before the item reads anything.
  always_ff @(posedge clk) begin
    if (rst || hist_clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        run_sum[i] <= '0;
        fill[i]    <= '0;
        oldest[i]  <= '0;
        lp_prev[i] <= '0;
      end
    end else if (ma_go) begin
      run_sum[ch_idx] <= sum_next;
      fill[ch_idx]    <= fill_next;
      if (is_full) oldest[ch_idx] <= oldest_next;
    end else if (state == ST_MULTIPLY && mul_done) begin
      lp_prev[ch_idx] <= lp_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) hist_rd <= hist[rd_addr];
    if (ma_go) hist[wr_addr] <= x_q;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q  <= channel;
      x_q   <= action_in;
      bad_q <= (32'(channel) >= CHANNELS);
    end
    if (state == ST_UPDATE) begin
      neg_q <= sum_next[SUM_W-1];
      res_q <= bad_q ? '0 : x_q;
    end else if (state == ST_DIVIDE && div_done) begin
      res_q <= avg_full[SAMPLE_BITS-1:0];
    end else if (state == ST_MULTIPLY && mul_done) begin
      res_q <= lp_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      channel_out <= ch_q;
      action_out  <= res_q;
      bad_channel <= bad_q;
    end
  end

endmodule
